// ===== rtl/sir_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sir_pkg
// Shared types, constants and helpers of the sphere collision resolver.
// ---------------------------------------------------------------------------
package sir_pkg;

	localparam int MAX_BODIES_DEF = 16;
	localparam int COINCIDENT_Q16 = 66;

	localparam logic [15:0] RADIUS_RST = 16'd16640;
	localparam logic [7:0]  REST_RST   = 8'd77;
	localparam logic [30:0] LIMIT_RST  = 31'd12800000;
	localparam logic [15:0] MARGIN_RST = 16'd256;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_REST   = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;
	localparam logic [1:0] REG_MARGIN = 2'd3;

	typedef struct packed {
		logic            active;
		logic [11:0]     mass;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
	} body_t;

	typedef struct packed {
		logic [15:0] radius;
		logic [7:0]  rest;
		logic [30:0] limit;
		logic [15:0] margin;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic        sqrt;
		logic [35:0] num;
		logic [16:0] den;
	} ds_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} ds_rsp_t;

	function automatic logic [31:0] sat32(input logic signed [33:0] x);
		logic [31:0] r;
		if (x > 34'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (x < -34'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sphere_impulse_collision_resolver_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sphere_impulse_collision_resolver_top
// Loads body records, resolves every pair i<j with impulse response and
// push-apart, then emits the updated records in load order.
// ---------------------------------------------------------------------------
// Records are taken one per cycle into a record RAM of MAX_BODIES entries;
// records beyond that are dropped. The record marked last_body starts the
// pair pass and the input stalls until all results are transferred. Each
// pair is fetched from the RAM, started and written back around the
// resolver, which ends early when a body is inactive, when the per-axis
// test fails, when the squared distance is out of range or coincident,
// and when the bodies do not approach; a contacting pair runs in full. The long
// cases are set by the bit-serial divide/sqrt unit: one 18-step square root,
// three 32-step divisions for the normal, one for the reduced mass and six
// for the velocity updates. Emission reads each record through the single
// RAM read port and waits out any output stall.
// ---------------------------------------------------------------------------
module sphere_impulse_collision_resolver_top #(
	parameter int MAX_BODIES = sir_pkg::MAX_BODIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        active,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] vel_x,
	input  wire logic [31:0] vel_y,
	input  wire logic [31:0] vel_z,
	input  wire logic [11:0] mass,
	input  wire logic        last_body,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       body_index,
	output logic [31:0]      new_pos_x,
	output logic [31:0]      new_pos_y,
	output logic [31:0]      new_pos_z,
	output logic [31:0]      new_vel_x,
	output logic [31:0]      new_vel_y,
	output logic [31:0]      new_vel_z,
	output logic             final_body
);

	localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int CW = $clog2(MAX_BODIES + 1);
	localparam int BW = $bits(sir_pkg::body_t);

	localparam logic [3:0] T_LOAD = 4'd0, T_RDA = 4'd1, T_RDB = 4'd2, T_CAPB = 4'd3;
	localparam logic [3:0] T_GO   = 4'd4, T_WAIT = 4'd5, T_WRA = 4'd6, T_WRB = 4'd7;
	localparam logic [3:0] T_ERD  = 4'd8, T_ELD = 4'd9, T_EHOLD = 4'd10;

	logic [3:0]    st_q;
	logic [CW-1:0] count_q, i_q, j_q, k_q;
	sir_pkg::cfg_t cfg_q;
	sir_pkg::body_t a_q, b_q, in_rec, res_a, res_b, rd_rec;
	logic          out_valid_q, final_q;
	logic [3:0]    index_q;
	logic [2:0][31:0] opos_q, ovel_q;

	logic          in_xfer, room, pair_start, pair_done;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [BW-1:0] wdata, rdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != T_LOAD);
	assign in_xfer   = in_valid && !in_stall;
	assign room      = (count_q < CW'(MAX_BODIES));
	assign pair_start = (st_q == T_GO);
	assign rd_rec    = rdata;

	always_comb begin
		in_rec.active = active;
		in_rec.mass   = mass;
		in_rec.pos    = {pos_z, pos_y, pos_x};
		in_rec.vel    = {vel_z, vel_y, vel_x};
	end

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = in_rec;
		case (st_q)
			T_LOAD: we = in_xfer && room;
			T_WRA: begin
				we    = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = res_a;
			end
			T_WRB: begin
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				wdata = res_b;
			end
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		case (st_q)
			T_RDA:   raddr = i_q[AW-1:0];
			T_RDB:   raddr = j_q[AW-1:0];
			default: raddr = k_q[AW-1:0];
		endcase
	end

	sir_ram #(
		.WIDTH (BW),
		.DEPTH (MAX_BODIES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	sir_pair u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (pair_start),
		.a_in   (a_q),
		.b_in   (b_q),
		.done   (pair_done),
		.a_out  (res_a),
		.b_out  (res_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= sir_pkg::RADIUS_RST;
			cfg_q.rest   <= sir_pkg::REST_RST;
			cfg_q.limit  <= sir_pkg::LIMIT_RST;
			cfg_q.margin <= sir_pkg::MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sir_pkg::REG_RADIUS: cfg_q.radius <= cfg_data[15:0];
				sir_pkg::REG_REST:   cfg_q.rest   <= cfg_data[7:0];
				sir_pkg::REG_LIMIT:  cfg_q.limit  <= cfg_data[30:0];
				sir_pkg::REG_MARGIN: cfg_q.margin <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_LOAD;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				T_LOAD: begin
					if (in_xfer) begin
						if (room) count_q <= count_q + CW'(1);
						if (last_body) begin
							i_q <= '0;
							j_q <= CW'(1);
							k_q <= '0;
							if (room ? (count_q >= CW'(1)) : 1'b1) begin
								st_q <= T_RDA;
							end else begin
								st_q <= T_ERD;
							end
						end
					end
				end
				T_RDA:  st_q <= T_RDB;
				T_RDB:  st_q <= T_CAPB;
				T_CAPB: st_q <= T_GO;
				T_GO:   st_q <= T_WAIT;
				T_WAIT: if (pair_done) st_q <= T_WRA;
				T_WRA:  st_q <= T_WRB;
				T_WRB: begin
					if (j_q + CW'(1) < count_q) begin
						j_q  <= j_q + CW'(1);
						st_q <= T_RDA;
					end else if (i_q + CW'(2) < count_q) begin
						i_q  <= i_q + CW'(1);
						j_q  <= i_q + CW'(2);
						st_q <= T_RDA;
					end else begin
						st_q <= T_ERD;
					end
				end
				T_ERD:  st_q <= T_ELD;
				T_ELD: begin
					out_valid_q <= 1'b1;
					st_q        <= T_EHOLD;
				end
				T_EHOLD: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (final_q) begin
							count_q <= '0;
							st_q    <= T_LOAD;
						end else begin
							k_q  <= k_q + CW'(1);
							st_q <= T_ERD;
						end
					end
				end
				default: st_q <= T_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == T_RDB) a_q <= rd_rec;
		if (st_q == T_CAPB) b_q <= rd_rec;
		if (st_q == T_ELD) begin
			index_q <= 4'(k_q);
			final_q <= (k_q + CW'(1) == count_q);
			opos_q  <= rd_rec.pos;
			ovel_q  <= rd_rec.vel;
		end
	end

	assign out_valid  = out_valid_q;
	assign body_index = index_q;
	assign final_body = final_q;
	assign new_pos_x  = opos_q[0];
	assign new_pos_y  = opos_q[1];
	assign new_pos_z  = opos_q[2];
	assign new_vel_x  = ovel_q[0];
	assign new_vel_y  = ovel_q[1];
	assign new_vel_z  = ovel_q[2];

`ifndef ASSERT_OFF
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result pending while input open");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_BODIES))
		else $error("record count beyond store depth");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		pair_start |-> (j_q > i_q) && (j_q < count_q))
		else $error("pair indices out of order");
`endif

endmodule
`default_nettype wire

// ===== rtl/sir_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sir_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/sir_divsqrt.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sir_divsqrt
// Bit-serial unit: 32-bit by 17-bit restoring divide, or 36-bit integer
// square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module sir_divsqrt (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sir_pkg::ds_req_t req,
	output sir_pkg::ds_rsp_t      rsp
);

	logic        busy_q, sqrt_q, done_q;
	logic [5:0]  cnt_q;
	logic [35:0] x_q;
	logic [21:0] rem_q;
	logic [31:0] root_q;
	logic [16:0] den_q;

	logic [17:0] dsh;
	logic        dge;
	logic [21:0] r2, trial;
	logic        sge;

	always_comb begin
		dsh   = {rem_q[16:0], x_q[35]};
		dge   = dsh >= {1'b0, den_q};
		r2    = {rem_q[19:0], x_q[35:34]};
		trial = {2'b00, root_q[17:0], 2'b01};
		sge   = r2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.sqrt ? 6'd18 : 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.sqrt;
			x_q    <= req.sqrt ? req.num : {req.num[31:0], 4'b0000};
			den_q  <= req.den;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (sqrt_q) begin
				rem_q  <= sge ? (r2 - trial) : r2;
				root_q <= {root_q[30:0], sge};
				x_q    <= {x_q[33:0], 2'b00};
			end else begin
				rem_q  <= 22'(dge ? (dsh - {1'b0, den_q}) : dsh);
				root_q <= {root_q[30:0], dge};
				x_q    <= {x_q[34:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = root_q;

endmodule
`default_nettype wire

// ===== rtl/sir_pair.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sir_pair
// Resolves one body pair: contact test, normal, impulse and push-apart,
// sequenced over one shared multiplier and the shared divide/sqrt unit.
// ---------------------------------------------------------------------------
module sir_pair (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sir_pkg::cfg_t  cfg,
	input  wire logic           start,
	input  wire sir_pkg::body_t a_in,
	input  wire sir_pkg::body_t b_in,
	output logic                done,
	output sir_pkg::body_t      a_out,
	output sir_pkg::body_t      b_out
);

	localparam logic [4:0] S_IDLE = 5'd0,  S_DIFF = 5'd1,  S_CHK = 5'd2,   S_SQ = 5'd3;
	localparam logic [4:0] S_SQA  = 5'd4,  S_MD   = 5'd5,  S_MDA = 5'd6,   S_SQRT = 5'd7;
	localparam logic [4:0] S_NGO  = 5'd8,  S_NW   = 5'd9,  S_SM  = 5'd10,  S_SA = 5'd11;
	localparam logic [4:0] S_SCHK = 5'd12, S_MU1  = 5'd13, S_MU2 = 5'd14,  S_MU3 = 5'd15;
	localparam logic [4:0] S_J1   = 5'd16, S_J2   = 5'd17, S_J3  = 5'd18,  S_J4 = 5'd19;
	localparam logic [4:0] S_J5   = 5'd20, S_J6   = 5'd21, S_U1  = 5'd22,  S_U2 = 5'd23;
	localparam logic [4:0] S_U3   = 5'd24, S_U4   = 5'd25, S_U5  = 5'd26,  S_U6 = 5'd27;
	localparam logic [4:0] S_FIN  = 5'd28;

	logic [4:0]  st_q;
	logic [1:0]  c_q;
	sir_pkg::body_t a_q, b_q;
	logic [11:0] ma_q, mb_q;
	logic [2:0]  dneg_q;
	logic [2:0][32:0] dmag_q;
	logic [2:0][15:0] an_q;
	logic [35:0] acc_q;
	logic [16:0] dist_q;
	logic signed [53:0] sacc_q;
	logic [34:0] vn_q;
	logic [19:0] mu_q;
	logic [43:0] p1_q;
	logic [41:0] jacc_q;
	logic [30:0] jm_q;
	logic [17:0] push_q;
	logic [30:0] t_q;
	logic [31:0] da_q, db_q;
	logic signed [61:0] p_q;

	logic [16:0] min_dist;
	logic signed [36:0] ma_op;
	logic signed [24:0] mb_op;
	logic signed [32:0] vdiff;
	logic signed [16:0] nsg;
	logic [2:0][32:0] dmag_n;
	logic [2:0]  dneg_n;
	logic        far, pass;
	logic [12:0] msum;
	logic [63:0] jfull;
	logic [47:0] j48;
	logic [16:0] gap;
	logic signed [33:0] va34, vb34, pa34, pb34, da34, db34, dp34;
	logic signed [33:0] vna, vnb, pna, pnb;
	sir_pkg::ds_req_t ds_req;
	sir_pkg::ds_rsp_t ds_rsp;

	sir_divsqrt u_ds (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.rsp    (ds_rsp)
	);

	always_comb begin
		logic signed [32:0] d;
		min_dist = {cfg.radius, 1'b0};
		far = 1'b0;
		for (int k = 0; k < 3; k++) begin
			d = $signed({b_q.pos[k][31], b_q.pos[k]}) - $signed({a_q.pos[k][31], a_q.pos[k]});
			dneg_n[k] = d[32];
			dmag_n[k] = d[32] ? 33'(-d) : 33'(d);
			far = far | (dmag_q[k] >= 33'(min_dist));
		end
		pass  = (acc_q < 36'(p_q[34:0])) && (acc_q >= 36'(sir_pkg::COINCIDENT_Q16));
		msum  = 13'(ma_q) + 13'(mb_q);
		vdiff = $signed({a_q.vel[c_q][31], a_q.vel[c_q]})
			- $signed({b_q.vel[c_q][31], b_q.vel[c_q]});
		nsg   = dneg_q[c_q] ? -$signed({1'b0, an_q[c_q]}) : $signed({1'b0, an_q[c_q]});
		jfull = (64'(p_q[42:0]) << 21) + 64'(jacc_q);
		j48   = jfull[63:16];
		gap   = min_dist - dist_q;
		va34  = 34'($signed(a_q.vel[c_q]));
		vb34  = 34'($signed(b_q.vel[c_q]));
		pa34  = 34'($signed(a_q.pos[c_q]));
		pb34  = 34'($signed(b_q.pos[c_q]));
		da34  = $signed({2'b00, da_q});
		db34  = $signed({2'b00, db_q});
		dp34  = $signed(34'(p_q[33:15]));
		vna   = dneg_q[c_q] ? va34 + da34 : va34 - da34;
		vnb   = dneg_q[c_q] ? vb34 - db34 : vb34 + db34;
		pna   = dneg_q[c_q] ? pa34 + dp34 : pa34 - dp34;
		pnb   = dneg_q[c_q] ? pb34 - dp34 : pb34 + dp34;
	end

	always_comb begin
		ma_op = '0;
		mb_op = '0;
		case (st_q)
			S_SQ: begin
				ma_op = 37'(dmag_q[c_q][16:0]);
				mb_op = 25'(dmag_q[c_q][16:0]);
			end
			S_MD: begin
				ma_op = 37'(min_dist);
				mb_op = 25'(min_dist);
			end
			S_SM: begin
				ma_op = 37'(vdiff);
				mb_op = 25'(nsg);
			end
			S_MU1: begin
				ma_op = 37'(ma_q);
				mb_op = 25'(mb_q);
			end
			S_J1: begin
				ma_op = 37'(vn_q);
				mb_op = 25'(9'(cfg.rest) + 9'd256);
			end
			S_J3: begin
				ma_op = 37'(p1_q[20:0]);
				mb_op = 25'(mu_q);
			end
			S_J5: begin
				ma_op = 37'(p1_q[43:21]);
				mb_op = 25'(mu_q);
			end
			S_U1: begin
				ma_op = 37'(jm_q);
				mb_op = 25'(an_q[c_q]);
			end
			S_U5: begin
				ma_op = 37'(push_q);
				mb_op = 25'(an_q[c_q]);
			end
			default: begin
				ma_op = '0;
				mb_op = '0;
			end
		endcase
	end

	always_comb begin
		ds_req.start = 1'b0;
		ds_req.sqrt  = 1'b0;
		ds_req.num   = '0;
		ds_req.den   = '0;
		case (st_q)
			S_MDA: begin
				ds_req.start = pass;
				ds_req.sqrt  = 1'b1;
				ds_req.num   = acc_q;
			end
			S_NGO: begin
				ds_req.start = 1'b1;
				ds_req.num   = 36'({dmag_q[c_q][16:0], 15'd0});
				ds_req.den   = dist_q;
			end
			S_MU2: begin
				ds_req.start = 1'b1;
				ds_req.num   = 36'({p_q[23:0], 8'd0});
				ds_req.den   = 17'(msum);
			end
			S_U2: begin
				ds_req.start = 1'b1;
				ds_req.num   = 36'(p_q[45:15]);
				ds_req.den   = 17'(ma_q);
			end
			S_U3: begin
				ds_req.start = ds_rsp.done;
				ds_req.num   = 36'(t_q);
				ds_req.den   = 17'(mb_q);
			end
			default: begin
				ds_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= ma_op * mb_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			c_q  <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					c_q <= '0;
					if (start) st_q <= S_DIFF;
				end
				S_DIFF: st_q <= (a_q.active && b_q.active) ? S_CHK : S_FIN;
				S_CHK:  st_q <= far ? S_FIN : S_SQ;
				S_SQ:   st_q <= S_SQA;
				S_SQA: begin
					if (c_q == 2'd2) begin
						c_q  <= '0;
						st_q <= S_MD;
					end else begin
						c_q  <= c_q + 2'd1;
						st_q <= S_SQ;
					end
				end
				S_MD:   st_q <= S_MDA;
				S_MDA:  st_q <= pass ? S_SQRT : S_FIN;
				S_SQRT: if (ds_rsp.done) st_q <= S_NGO;
				S_NGO:  st_q <= S_NW;
				S_NW: begin
					if (ds_rsp.done) begin
						if (c_q == 2'd2) begin
							c_q  <= '0;
							st_q <= S_SM;
						end else begin
							c_q  <= c_q + 2'd1;
							st_q <= S_NGO;
						end
					end
				end
				S_SM:   st_q <= S_SA;
				S_SA: begin
					if (c_q == 2'd2) begin
						c_q  <= '0;
						st_q <= S_SCHK;
					end else begin
						c_q  <= c_q + 2'd1;
						st_q <= S_SM;
					end
				end
				S_SCHK: st_q <= (sacc_q > 54'sd0) ? S_MU1 : S_FIN;
				S_MU1:  st_q <= S_MU2;
				S_MU2:  st_q <= S_MU3;
				S_MU3:  if (ds_rsp.done) st_q <= S_J1;
				S_J1:   st_q <= S_J2;
				S_J2:   st_q <= S_J3;
				S_J3:   st_q <= S_J4;
				S_J4:   st_q <= S_J5;
				S_J5:   st_q <= S_J6;
				S_J6:   st_q <= S_U1;
				S_U1:   st_q <= S_U2;
				S_U2:   st_q <= S_U3;
				S_U3:   if (ds_rsp.done) st_q <= S_U4;
				S_U4:   if (ds_rsp.done) st_q <= S_U5;
				S_U5:   st_q <= S_U6;
				S_U6: begin
					if (c_q == 2'd2) begin
						st_q <= S_FIN;
					end else begin
						c_q  <= c_q + 2'd1;
						st_q <= S_U1;
					end
				end
				S_FIN:  st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (start) begin
					a_q  <= a_in;
					b_q  <= b_in;
					ma_q <= (a_in.mass == 12'd0) ? 12'd1 : a_in.mass;
					mb_q <= (b_in.mass == 12'd0) ? 12'd1 : b_in.mass;
				end
			end
			S_DIFF: begin
				dneg_q <= dneg_n;
				dmag_q <= dmag_n;
				acc_q  <= '0;
			end
			S_SQA:  acc_q <= acc_q + p_q[35:0];
			S_SQRT: if (ds_rsp.done) dist_q <= ds_rsp.res[16:0];
			S_NW: begin
				if (ds_rsp.done) an_q[c_q] <= ds_rsp.res[15:0];
				sacc_q <= '0;
			end
			S_SA:   sacc_q <= sacc_q + 54'(p_q);
			S_SCHK: vn_q <= 35'(sacc_q[49:15]);
			S_MU3:  if (ds_rsp.done) mu_q <= ds_rsp.res[19:0];
			S_J2:   p1_q <= p_q[43:0];
			S_J4:   jacc_q <= p_q[41:0];
			S_J6: begin
				jm_q   <= (j48 > 48'(cfg.limit)) ? cfg.limit : j48[30:0];
				push_q <= 18'(gap[16:1]) + 18'(cfg.margin);
			end
			S_U2:   t_q <= p_q[45:15];
			S_U3:   if (ds_rsp.done) da_q <= ds_rsp.res;
			S_U4:   if (ds_rsp.done) db_q <= ds_rsp.res;
			S_U6: begin
				a_q.vel[c_q] <= sir_pkg::sat32(vna);
				b_q.vel[c_q] <= sir_pkg::sat32(vnb);
				a_q.pos[c_q] <= sir_pkg::sat32(pna);
				b_q.pos[c_q] <= sir_pkg::sat32(pnb);
			end
			default: begin
			end
		endcase
	end

	assign done  = (st_q == S_FIN);
	assign a_out = a_q;
	assign b_out = b_q;

endmodule
`default_nettype wire

// ===== verif/tb_sphere_impulse_collision_resolver_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sphere_impulse_collision_resolver_top
// Sends sets of body records and predicts every resolved record in the
// testbench. The pair pass uses the same fixed-point steps as the block.
// Each emitted record is checked field by field, in order. The run uses
// several register settings and random gaps on input and output.
// ---------------------------------------------------------------------------

typedef struct {
	logic [3:0]  idx;
	logic [31:0] pos [3];
	logic [31:0] vel [3];
	logic        fin;
} rec_t;

class body_ledger;
	longint unsigned radius, rest, limit, margin;
	longint          pos [3][16];
	longint          vel [3][16];
	longint unsigned mass [16];
	bit              act [16];
	int unsigned     count;
	rec_t            expected_records [$];
	int              errors;
	int              contacts;
	int              results;

	function new();
		radius = sir_pkg::RADIUS_RST;
		rest   = sir_pkg::REST_RST;
		limit  = sir_pkg::LIMIT_RST;
		margin = sir_pkg::MARGIN_RST;
	endfunction

	function void set_reg(logic [1:0] index, logic [31:0] data);
		case (index)
			sir_pkg::REG_RADIUS: radius = data[15:0];
			sir_pkg::REG_REST:   rest   = data[7:0];
			sir_pkg::REG_LIMIT:  limit  = data[30:0];
			sir_pkg::REG_MARGIN: margin = data[15:0];
			default: ;
		endcase
	endfunction

	function longint unsigned mag(longint x);
		return x < 0 ? longint'(-x) : x;
	endfunction

	function longint sat(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function longint unsigned root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function void apply_contact(int a, int b);
		longint          d [3], n [3], s, da, db, dp, q;
		longint unsigned md, dsq, dlen, mu, vn, jm, ma, mb, push, an, mg;
		md = radius * 2;
		dsq = 0;
		s = 0;
		ma = mass[a];
		mb = mass[b];
		for (int c = 0; c < 3; c++) begin
			d[c] = pos[c][b] - pos[c][a];
			mg = mag(d[c]);
			if (mg >= md) return;
			dsq += mg * mg;
		end
		if (dsq >= md * md || dsq < sir_pkg::COINCIDENT_Q16) return;
		dlen = root(dsq);
		for (int c = 0; c < 3; c++) begin
			q = longint'((mag(d[c]) << 15) / dlen);
			n[c] = d[c] < 0 ? -q : q;
			s += (vel[c][a] - vel[c][b]) * n[c];
		end
		if (s <= 0) return;
		contacts++;
		vn = longint'(s) >> 15;
		if (ma == 0) ma = 1;
		if (mb == 0) mb = 1;
		mu = (ma * mb * 256) / (ma + mb);
		jm = (vn * (256 + rest) * mu) >> 16;
		if (jm > limit) jm = limit;
		push = ((md - dlen) >> 1) + margin;
		for (int c = 0; c < 3; c++) begin
			an = mag(n[c]);
			da = longint'((jm * an) / (ma << 15));
			db = longint'((jm * an) / (mb << 15));
			dp = longint'((an * push) >> 15);
			if (n[c] < 0) begin
				da = -da;
				db = -db;
				dp = -dp;
			end
			vel[c][a] = sat(vel[c][a] - da);
			vel[c][b] = sat(vel[c][b] + db);
			pos[c][a] = sat(pos[c][a] - dp);
			pos[c][b] = sat(pos[c][b] + dp);
		end
	endfunction

	function void note_body(logic a, logic [31:0] p [3], logic [31:0] v [3],
			logic [11:0] m, logic lst);
		rec_t r;
		if (count < 16) begin
			act[count] = a;
			for (int c = 0; c < 3; c++) begin
				pos[c][count] = longint'(signed'(p[c]));
				vel[c][count] = longint'(signed'(v[c]));
			end
			mass[count] = m;
			count++;
		end
		if (!lst) return;
		for (int i = 0; i < count; i++) begin
			if (!act[i]) continue;
			for (int j = i + 1; j < count; j++)
				if (act[j]) apply_contact(i, j);
		end
		for (int i = 0; i < count; i++) begin
			r.idx = i[3:0];
			for (int c = 0; c < 3; c++) begin
				r.pos[c] = pos[c][i][31:0];
				r.vel[c] = vel[c][i][31:0];
			end
			r.fin = (i + 1 == count);
			expected_records.push_back(r);
		end
		count = 0;
	endfunction

	function void cmp(string name, logic [31:0] e, logic [31:0] g);
		if (e !== g) begin
			$error("%s: expected %0h, got %0h", name, e, g);
			errors++;
		end
	endfunction

	function void check_record(rec_t g);
		rec_t e;
		results++;
		if (expected_records.size() == 0) begin
			$error("record %0d emitted with nothing expected", g.idx);
			errors++;
			return;
		end
		e = expected_records.pop_front();
		cmp("body_index", e.idx, g.idx);
		cmp("new_pos_x", e.pos[0], g.pos[0]);
		cmp("new_pos_y", e.pos[1], g.pos[1]);
		cmp("new_pos_z", e.pos[2], g.pos[2]);
		cmp("new_vel_x", e.vel[0], g.vel[0]);
		cmp("new_vel_y", e.vel[1], g.vel[1]);
		cmp("new_vel_z", e.vel[2], g.vel[2]);
		cmp("final_body", e.fin, g.fin);
	endfunction
endclass

module tb_sphere_impulse_collision_resolver_top;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int ITEMS = 450;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = sir_pkg::REG_RADIUS;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        active = 0;
	logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic [11:0] mass = 12'd1;
	logic        last_body = 0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [3:0]  body_index;
	logic [31:0] new_pos_x, new_pos_y, new_pos_z;
	logic [31:0] new_vel_x, new_vel_y, new_vel_z;
	logic        final_body;

	body_ledger ledger = new();
	int  items_sent;
	int  sets_sent;
	int  settings_used;
	int  idle_cycles;
	bit  no_gaps;
	bit  long_hold;

	sphere_impulse_collision_resolver_top dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		rec_t g;
		if (arst_n && out_valid && !out_stall) begin
			g.idx = body_index;
			g.pos[0] = new_pos_x;
			g.pos[1] = new_pos_y;
			g.pos[2] = new_pos_z;
			g.vel[0] = new_vel_x;
			g.vel[1] = new_vel_y;
			g.vel[2] = new_vel_z;
			g.fin = final_body;
			ledger.check_record(g);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL sphere_impulse_collision_resolver_top");
			$finish;
		end
	end

	// receiver: random stall before each transfer, one long hold on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = no_gaps ? 0 : $urandom_range(0, 13);
			if (long_hold) begin
				n = 600;
				long_hold = 0;
			end
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_reg(index, data);
	endtask

	task automatic settle();
		while (ledger.expected_records.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_regs(logic [15:0] r, logic [7:0] e, logic [30:0] l, logic [15:0] m);
		in_valid <= 0;
		settle();
		write_reg(sir_pkg::REG_RADIUS, r);
		write_reg(sir_pkg::REG_REST, e);
		write_reg(sir_pkg::REG_LIMIT, l);
		write_reg(sir_pkg::REG_MARGIN, m);
		cfg_valid <= 0;
		settings_used++;
	endtask

	task automatic send_body(logic a, logic [31:0] p [3], logic [31:0] v [3],
			logic [11:0] m, logic lst);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		active <= a;
		pos_x <= p[0];
		pos_y <= p[1];
		pos_z <= p[2];
		vel_x <= v[0];
		vel_y <= v[1];
		vel_z <= v[2];
		mass <= m;
		last_body <= lst;
		do @(posedge clk); while (in_stall);
		ledger.note_body(a, p, v, m, lst);
		items_sent++;
		if (lst) sets_sent++;
	endtask

	// a set clustered so that spheres touch; a few bodies are full-range noise
	task automatic send_set(int size);
		logic [31:0] p [3], v [3];
		longint      ctr [3];
		longint      spread;
		logic [11:0] m;
		logic        a;
		spread = ledger.radius * $urandom_range(1, 4) + $urandom_range(0, 300);
		for (int c = 0; c < 3; c++)
			case ($urandom_range(0, 5))
				0: ctr[c] = 64'sd2147483647 - $urandom_range(0, 2000);
				1: ctr[c] = -64'sd2147483648 + $urandom_range(0, 2000);
				default: ctr[c] = longint'(signed'(32'($urandom())));
			endcase
		for (int k = 0; k < size; k++) begin
			for (int c = 0; c < 3; c++) begin
				p[c] = 32'(ctr[c] + longint'($urandom_range(0, 2 * spread)) - spread);
				case ($urandom_range(0, 7))
					0: v[c] = $urandom();
					1: v[c] = 32'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
					default: v[c] = 32'(int'($urandom_range(0, 200000)) - 100000);
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				for (int c = 0; c < 3; c++) p[c] = $urandom();
			end
			case ($urandom_range(0, 5))
				0: m = 12'd1;
				1: m = 12'd4095;
				default: m = 12'($urandom_range(1, 4095));
			endcase
			a = $urandom_range(0, 7) != 0;
			send_body(a, p, v, m, k == size - 1);
		end
	endtask

	task automatic run_random(int upto);
		int size;
		while (items_sent < upto) begin
			case ($urandom_range(0, 19))
				0: size = 16;
				1: size = 18;
				2: size = 1;
				default: size = $urandom_range(2, 6);
			endcase
			no_gaps = $urandom_range(0, 5) == 0;
			send_set(size);
		end
		no_gaps = 0;
	endtask

	initial begin
		logic [31:0] p [3], v [3], q [3], w [3];
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// lone body with extreme fields
		p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
		v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
		send_body(1, p, v, 12'd4095, 1);
		// coincident centres are skipped
		v = '{32'd500, 32'd0, 32'd0};
		w = '{-32'sd500, 32'd0, 32'd0};
		p = '{32'd1000, 32'd2000, 32'd3000};
		send_body(1, p, v, 12'd1, 0);
		send_body(1, p, w, 12'd10, 1);
		// head-on pair with an inactive body in between
		q = '{32'd1000 + 32'd20000, 32'd2000, 32'd3000};
		send_body(1, p, v, 12'd3, 0);
		send_body(0, p, w, 12'd7, 0);
		send_body(1, q, w, 12'd5, 1);
		// store overflow: extra records dropped, last still starts the pass
		for (int k = 0; k < 17; k++) begin
			p = '{32'(k * 9000), 32'(k * 100), 32'h0};
			v = '{32'(1000 - k * 120), 32'(k * 7), 32'h0};
			send_body(k != 5, p, v, 12'(k * 200 + 1), k == 16);
		end

		run_random(ITEMS / 6);
		// long output hold while the next set is already offered
		long_hold = 1;
		send_set(16);
		send_set(4);
		load_regs(16'hFFFF, 8'hFF, 31'h7FFF_FFFF, 16'hFFFF);
		run_random(2 * ITEMS / 6);
		load_regs(16'h0, 8'h0, 31'h0, 16'h0);
		run_random(3 * ITEMS / 6);
		load_regs(16'd16640, 8'h0, 31'd1000, 16'h0);
		run_random(4 * ITEMS / 6);
		load_regs(16'd40000, 8'hFF, 31'h7FFF_FFFF, 16'd1);
		run_random(5 * ITEMS / 6);
		load_regs(16'($urandom()), 8'($urandom()), 31'($urandom()), 16'($urandom()));
		run_random(ITEMS);
		in_valid <= 0;

		settle();
		repeat (50) @(posedge clk);
		$display("Ran %0d records in %0d sets under %0d register settings;",
			items_sent, sets_sent, settings_used + 1);
		$display("checked %0d emitted records, %0d impulse contacts.",
			ledger.results, ledger.contacts);
		if (ledger.errors == 0 && ledger.expected_records.size() == 0)
			$display("PASS sphere_impulse_collision_resolver_top");
		else
			$display("FAIL sphere_impulse_collision_resolver_top");
		$finish;
	end
endmodule
